/* sv/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants of the pixel format converter
// formats, register indexes, stream widths and palette transaction types
// ----------------------------------------------------------------------------
package pfc_pkg;

   // pixel format codes
   typedef enum logic [1:0] {
      FMT_INDEX8   = 2'd0,
      FMT_RGB565   = 2'd1,
      FMT_RGB888   = 2'd2,
      FMT_ARGB8888 = 2'd3
   } pfc_format_type;

   // configuration register indexes
   typedef enum logic {
      REG_SOURCE_FORMAT = 1'b0,
      REG_TARGET_FORMAT = 1'b1
   } pfc_reg_type;

   // transaction kinds on the request side
   typedef enum logic {
      KIND_PIXEL       = 1'b0,
      KIND_PALETTE_WR  = 1'b1
   } pfc_kind_type;

   localparam int unsigned PIXEL_W   = 32;
   localparam int unsigned INDEX_W   = 8;
   localparam int unsigned COLOR_W   = 24;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 2;

   // divide-by-three of a channel sum below 768: (s * 683) >> 11
   localparam int unsigned SUM_W      = 10;
   localparam int unsigned DIV3_RECIP = 683;
   localparam int unsigned DIV3_SHIFT = 11;
   localparam int unsigned PROD_W     = 21;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // palette write transaction
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] color;
   } pfc_pal_wr_type;

endpackage

/* sv/pfc_palette.sv */
// ----------------------------------------------------------------------------
// pfc_palette: palette color store
// one write and one registered read per cycle; entries read zero until written
// ----------------------------------------------------------------------------
module pfc_palette #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pfc_pkg::pfc_pal_wr_type       wr,
   input  logic                          rd_en,
   input  logic [pfc_pkg::INDEX_W-1:0]   rd_index,
   output logic [pfc_pkg::COLOR_W-1:0]   rd_color
);

   localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);

   logic [pfc_pkg::COLOR_W-1:0] mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0]  valid_ff;
   logic [PALETTE_ENTRIES-1:0]  valid_in;
   logic [pfc_pkg::COLOR_W-1:0] rd_data_ff;
   logic                        rd_hit_ff;
   logic                        rd_hit_in;
   logic                        wr_in_range;
   logic                        rd_in_range;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr;

   // range checks against the configured depth
   assign wr_in_range = ({1'b0, wr.index} < (pfc_pkg::INDEX_W + 1)'(PALETTE_ENTRIES));
   assign rd_in_range = ({1'b0, rd_index} < (pfc_pkg::INDEX_W + 1)'(PALETTE_ENTRIES));
   assign wr_addr     = wr.index[ADDR_W-1:0];
   assign rd_addr     = rd_index[ADDR_W-1:0];

   // valid bits stand in for clearing the store at reset
   always_comb begin
      valid_in = valid_ff;
      if (wr.en && wr_in_range) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr_addr] <= wr.color;
      end
   end

   // registered read, hit flag kept beside the data
   assign rd_hit_in = rd_in_range && valid_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         rd_hit_ff <= rd_hit_in;
      end
   end

   assign rd_color = rd_hit_ff ? rd_data_ff : '0;

endmodule

/* sv/pixel_format_converter.sv */
// ----------------------------------------------------------------------------
// pixel_format_converter: one pixel per transaction between index8, rgb565,
// rgb888 and argb8888, with a palette store for index8 sources
// ----------------------------------------------------------------------------
// Takes one transaction per clock while req_tready is high and returns a pixel
// result per pixel. First comes the registered read of the palette store, which
// serves index8 sources; then the decode, conversion and output register.
// Palette writes (tuser high) update the store and give no result; a pixel that
// follows in the next cycle already sees the new color. The store reads as zero
// after reset until written. The user must set formats through the csr port
// only while no transaction is in flight; the block does not enforce this.
module pixel_format_converter #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = pixel_in[31:0], entry_index[39:32], entry_color[63:40]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // request: tuser = kind
   input  logic                              req_tuser,
   // response: tdata = pixel_out[31:0], update_color[55:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // response: tuser = palette_update
   output logic                              rsp_tuser,
   // configuration writes
   input  logic                              csr_we,
   input  logic [pfc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pfc_pkg::pfc_format_type           src_fmt_ff;
   pfc_pkg::pfc_format_type           dst_fmt_ff;
   logic                              req_accept;
   logic                              req_is_pixel;
   logic                              out_free;
   pfc_pkg::pfc_pal_wr_type           pal_wr;
   logic [pfc_pkg::COLOR_W-1:0]       pal_color;
   logic                              s1_valid_ff;
   logic [pfc_pkg::PIXEL_W-1:0]       s1_pixel_ff;
   logic                              rsp_valid_ff;
   logic [pfc_pkg::PIXEL_W-1:0]       rsp_pixel_ff;
   logic [pfc_pkg::PIXEL_W-1:0]       rsp_pixel_in;
   logic                              rsp_update_ff;
   logic                              rsp_update_in;
   logic [pfc_pkg::COLOR_W-1:0]       rsp_color_ff;
   logic [pfc_pkg::COLOR_W-1:0]       rsp_color_in;
   logic [pfc_pkg::COLOR_W-1:0]       color;
   logic [7:0]                        ch_r;
   logic [7:0]                        ch_g;
   logic [7:0]                        ch_b;
   logic [pfc_pkg::SUM_W-1:0]         sum;
   logic [pfc_pkg::PROD_W-1:0]        prod;
   logic [7:0]                        gray_index;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff <= pfc_pkg::FMT_ARGB8888;
         dst_fmt_ff <= pfc_pkg::FMT_ARGB8888;
      end else if (csr_we) begin
         unique case (pfc_pkg::pfc_reg_type'(csr_addr))
            pfc_pkg::REG_SOURCE_FORMAT: src_fmt_ff <= pfc_pkg::pfc_format_type'(csr_wdata);
            pfc_pkg::REG_TARGET_FORMAT: dst_fmt_ff <= pfc_pkg::pfc_format_type'(csr_wdata);
         endcase
      end
   end

   // handshake
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !s1_valid_ff || out_free;
   assign req_accept   = req_tvalid && req_tready;
   assign req_is_pixel = (pfc_pkg::pfc_kind_type'(req_tuser) == pfc_pkg::KIND_PIXEL);

   // palette store
   assign pal_wr.en    = req_accept && !req_is_pixel;
   assign pal_wr.index = req_tdata[39:32];
   assign pal_wr.color = req_tdata[63:40];

   pfc_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr       (pal_wr),
      .rd_en    (req_accept && req_is_pixel),
      .rd_index (req_tdata[7:0]),
      .rd_color (pal_color)
   );

   // first stage: pixel held beside the palette read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= req_is_pixel;
      end else if (out_free) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_is_pixel) begin
         s1_pixel_ff <= req_tdata[31:0];
      end
   end

   // decode source pixel to r:g:b
   always_comb begin
      unique case (src_fmt_ff)
         pfc_pkg::FMT_INDEX8:   color = pal_color;
         pfc_pkg::FMT_RGB565:   color = {s1_pixel_ff[15:11], 3'b000,
                                         s1_pixel_ff[10:5], 2'b00,
                                         s1_pixel_ff[4:0], 3'b000};
         pfc_pkg::FMT_RGB888,
         pfc_pkg::FMT_ARGB8888: color = s1_pixel_ff[23:0];
      endcase
   end

   assign ch_r = color[23:16];
   assign ch_g = color[15:8];
   assign ch_b = color[7:0];

   // gray index (r+g+b)/3 by reciprocal multiply
   assign sum        = pfc_pkg::SUM_W'(ch_r) + pfc_pkg::SUM_W'(ch_g) + pfc_pkg::SUM_W'(ch_b);
   assign prod       = pfc_pkg::PROD_W'(sum) * pfc_pkg::PROD_W'(pfc_pkg::DIV3_RECIP);
   assign gray_index = prod[pfc_pkg::DIV3_SHIFT +: 8];

   // encode into target format
   always_comb begin
      rsp_update_in = 1'b0;
      rsp_color_in  = '0;
      if (src_fmt_ff == dst_fmt_ff) begin
         unique case (src_fmt_ff)
            pfc_pkg::FMT_INDEX8:   rsp_pixel_in = {24'd0, s1_pixel_ff[7:0]};
            pfc_pkg::FMT_RGB565:   rsp_pixel_in = {16'd0, s1_pixel_ff[15:0]};
            pfc_pkg::FMT_RGB888:   rsp_pixel_in = {8'd0, s1_pixel_ff[23:0]};
            pfc_pkg::FMT_ARGB8888: rsp_pixel_in = s1_pixel_ff;
         endcase
      end else begin
         unique case (dst_fmt_ff)
            pfc_pkg::FMT_INDEX8: begin
               rsp_pixel_in  = {24'd0, gray_index};
               rsp_update_in = 1'b1;
               rsp_color_in  = color;
            end
            pfc_pkg::FMT_RGB565:   rsp_pixel_in = {16'd0, ch_r[7:3], ch_g[7:2], ch_b[7:3]};
            pfc_pkg::FMT_RGB888:   rsp_pixel_in = {8'd0, color};
            pfc_pkg::FMT_ARGB8888: rsp_pixel_in = {pfc_pkg::ALPHA_OPAQUE, color};
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_pixel_ff  <= rsp_pixel_in;
         rsp_update_ff <= rsp_update_in;
         rsp_color_ff  <= rsp_color_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_color_ff, rsp_pixel_ff};
   assign rsp_tuser  = rsp_update_ff;

endmodule

/* sv/pfc_checker.sv */
// ----------------------------------------------------------------------------
// pfc_checker: port-level checks of the pixel format converter
// watches the response stream port and is bound to the top level
// ----------------------------------------------------------------------------
module pfc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [pfc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              rsp_tuser
);

   // no result right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // a palette update carries an 8-bit index
   a_update_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[31:8] == 24'd0))
      else $error("palette update index above 8 bits");

   // update color is zero when no entry is set
   a_no_update_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[55:32] == 24'd0))
      else $error("update color without palette update");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pixel format converter
// Walks a short table of hand-picked pixels and palette writes over every
// source/target pairing, then random traffic through all sixteen format settings,
// most with random gaps and output stalls. Each pixel result is checked field
// by field against its table entry or an in-bench model with its own palette.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned ITEMS_PER_SETTING = 121;
   localparam int unsigned DRAIN_CYCLES      = 4;
   localparam int unsigned TIMEOUT_CYCLES    = 200000;

   // one converted pixel as seen on the response side
   typedef struct {
      logic [31:0] pixel_out;
      logic        palette_update;
      logic [23:0] update_color;
   } pixel_result_type;

   // one row of the directed table
   typedef struct {
      pfc_pkg::pfc_format_type source_fmt;
      pfc_pkg::pfc_format_type target_fmt;
      pfc_pkg::pfc_kind_type   kind;
      logic [31:0]             pixel;
      logic [7:0]              entry_index;
      logic [23:0]             entry_color;
      bit                      has_result;
      pixel_result_type        result;
   } directed_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pfc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pfc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_we = 1'b0;
   logic [pfc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [pfc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // conversion model state
   logic [23:0]             palette_model [256];
   pfc_pkg::pfc_format_type model_source_fmt;
   pfc_pkg::pfc_format_type model_target_fmt;

   pixel_result_type  expected_pixels [$];
   directed_row_type  directed_rows [$];
   bit                row_has_result = 1'b0;
   pixel_result_type  row_result = '{32'h0, 1'b0, 24'h0};
   bit                idle_on = 1'b1;
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;
   int                stall_left = 0;

   pixel_format_converter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected conversion of one pixel under the current formats
   function automatic pixel_result_type convert_pixel(logic [31:0] pixel);
      pixel_result_type res;
      logic [23:0]      color;
      logic [9:0]       sum;
      res = '{32'h0, 1'b0, 24'h0};
      if (model_source_fmt == model_target_fmt) begin
         case (model_source_fmt)
            pfc_pkg::FMT_INDEX8:   res.pixel_out = {24'h0, pixel[7:0]};
            pfc_pkg::FMT_RGB565:   res.pixel_out = {16'h0, pixel[15:0]};
            pfc_pkg::FMT_RGB888:   res.pixel_out = {8'h0, pixel[23:0]};
            default:               res.pixel_out = pixel;
         endcase
         return res;
      end
      // decode the source into 8-bit channels, no bit replication
      case (model_source_fmt)
         pfc_pkg::FMT_INDEX8: color = palette_model[pixel[7:0]];
         pfc_pkg::FMT_RGB565: color = {pixel[15:11], 3'b0, pixel[10:5], 2'b0,
                                       pixel[4:0], 3'b0};
         default:             color = pixel[23:0];
      endcase
      case (model_target_fmt)
         pfc_pkg::FMT_INDEX8: begin
            sum = 10'(color[23:16]) + 10'(color[15:8]) + 10'(color[7:0]);
            res.pixel_out      = 32'(sum / 10'd3);
            res.palette_update = 1'b1;
            res.update_color   = color;
         end
         pfc_pkg::FMT_RGB565: res.pixel_out = {16'h0, color[23:19], color[15:10],
                                               color[7:3]};
         pfc_pkg::FMT_RGB888: res.pixel_out = {8'h0, color};
         default:             res.pixel_out = {8'hFF, color};
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (mismatches < 10)
         $display("mismatch %s: expected %h, got %h", what, want, got);
      mismatches++;
   endtask

   // response check, output stalls and tracking of accepted requests
   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      int unsigned      stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tuser, rsp_tdata[55:32]};
            if (expected_pixels.size() == 0) begin
               report_mismatch("result with none pending", 32'h0, got.pixel_out);
            end else begin
               want = expected_pixels.pop_front();
               if (got.pixel_out !== want.pixel_out)
                  report_mismatch("pixel_out", want.pixel_out, got.pixel_out);
               if (got.palette_update !== want.palette_update)
                  report_mismatch("palette_update", 32'(want.palette_update),
                                  32'(got.palette_update));
               if (got.update_color !== want.update_color)
                  report_mismatch("update_color", 32'(want.update_color),
                                  32'(got.update_color));
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            rsp_tready <= (stall == 0);
            stall_left <= stall;
         end else if (!rsp_tready) begin
            if (stall_left <= 1)
               rsp_tready <= 1'b1;
            stall_left <= stall_left - 1;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == pfc_pkg::KIND_PALETTE_WR) begin
               palette_model[req_tdata[39:32]] = req_tdata[63:40];
            end else begin
               want = convert_pixel(req_tdata[31:0]);
               if (row_has_result)
                  want = row_result;
               expected_pixels.push_back(want);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // offer one request transaction and hold it until accepted
   task automatic send(pfc_pkg::pfc_kind_type kind, logic [31:0] pixel,
                       logic [7:0] entry_index, logic [23:0] entry_color,
                       bit has_result, pixel_result_type result);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid     <= 1'b1;
      req_tuser      <= kind;
      req_tdata      <= {entry_color, entry_index, pixel};
      row_has_result <= has_result;
      row_result     <= result;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and let every pending result and palette write drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_formats(pfc_pkg::pfc_format_type source_fmt,
                              pfc_pkg::pfc_format_type target_fmt);
      csr_we    <= 1'b1;
      csr_addr  <= pfc_pkg::REG_SOURCE_FORMAT;
      csr_wdata <= source_fmt;
      @(posedge clock);
      csr_addr  <= pfc_pkg::REG_TARGET_FORMAT;
      csr_wdata <= target_fmt;
      @(posedge clock);
      csr_we <= 1'b0;
      model_source_fmt = source_fmt;
      model_target_fmt = target_fmt;
   endtask

   task automatic add_row(pfc_pkg::pfc_format_type source_fmt,
                          pfc_pkg::pfc_format_type target_fmt,
                          pfc_pkg::pfc_kind_type kind, logic [31:0] pixel,
                          logic [7:0] entry_index, logic [23:0] entry_color,
                          bit has_result, logic [31:0] exp_pixel,
                          logic exp_update, logic [23:0] exp_color);
      directed_row_type row;
      row.source_fmt  = source_fmt;
      row.target_fmt  = target_fmt;
      row.kind        = kind;
      row.pixel       = pixel;
      row.entry_index = entry_index;
      row.entry_color = entry_color;
      row.has_result  = has_result;
      row.result      = '{exp_pixel, exp_update, exp_color};
      directed_rows.push_back(row);
   endtask

   initial begin
      pfc_pkg::pfc_kind_type kind;
      logic [31:0]           pixel;

      foreach (palette_model[i]) palette_model[i] = 24'h0;
      model_source_fmt = pfc_pkg::FMT_ARGB8888;
      model_target_fmt = pfc_pkg::FMT_ARGB8888;

      // directed table: reset setting first, then each source/target pairing
      add_row(pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, pfc_pkg::KIND_PIXEL,
              32'hFFFFFFFF, 8'h00, 24'h0, 1, 32'hFFFFFFFF, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, pfc_pkg::KIND_PIXEL,
              32'h00000000, 8'h00, 24'h0, 1, 32'h00000000, 1'b0, 24'h0);
      // palette reads as zero after reset; upper index bits ignored
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PIXEL,
              32'hFFFFFF12, 8'h00, 24'h0, 1, 32'h00000000, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PALETTE_WR,
              32'hFFFFFFFF, 8'hFF, 24'hFFFFFF, 0, 32'h0, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PALETTE_WR,
              32'h00000000, 8'h00, 24'h123456, 0, 32'h0, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PALETTE_WR,
              32'h00000000, 8'h07, 24'h00FF00, 0, 32'h0, 1'b0, 24'h0);
      // lookup right after the write
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PIXEL,
              32'h00000007, 8'h00, 24'h0, 1, 32'h0000FF00, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PIXEL,
              32'h000000FF, 8'h00, 24'h0, 1, 32'h00FFFFFF, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_ARGB8888, pfc_pkg::KIND_PIXEL,
              32'h00000000, 8'h00, 24'h0, 1, 32'hFF123456, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_RGB565, pfc_pkg::KIND_PIXEL,
              32'h000000FF, 8'h00, 24'h0, 1, 32'h0000FFFF, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_INDEX8, pfc_pkg::FMT_INDEX8, pfc_pkg::KIND_PIXEL,
              32'hFFFFFFFF, 8'h00, 24'h0, 1, 32'h000000FF, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PIXEL,
              32'h0000FFFF, 8'h00, 24'h0, 1, 32'h00F8FCF8, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_ARGB8888, pfc_pkg::KIND_PIXEL,
              32'hFFFF0000, 8'h00, 24'h0, 1, 32'hFF000000, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_INDEX8, pfc_pkg::KIND_PIXEL,
              32'h0000FFFF, 8'h00, 24'h0, 0, 32'h0, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_INDEX8, pfc_pkg::KIND_PIXEL,
              32'h0000A5C3, 8'h00, 24'h0, 0, 32'h0, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGB565, pfc_pkg::KIND_PIXEL,
              32'hFFFFFFFF, 8'h00, 24'h0, 1, 32'h0000FFFF, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_RGB565, pfc_pkg::KIND_PIXEL,
              32'h00FFFFFF, 8'h00, 24'h0, 1, 32'h0000FFFF, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_INDEX8, pfc_pkg::KIND_PIXEL,
              32'hFFFFFFFF, 8'h00, 24'h0, 1, 32'h000000FF, 1'b1, 24'hFFFFFF);
      add_row(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_INDEX8, pfc_pkg::KIND_PIXEL,
              32'h00010203, 8'h00, 24'h0, 0, 32'h0, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PIXEL,
              32'hFFFFFFFF, 8'h00, 24'h0, 1, 32'h00FFFFFF, 1'b0, 24'h0);
      // alpha forced opaque on argb output
      add_row(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_ARGB8888, pfc_pkg::KIND_PIXEL,
              32'h12ABCDEF, 8'h00, 24'h0, 1, 32'hFFABCDEF, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_RGB888, pfc_pkg::KIND_PIXEL,
              32'hFF000000, 8'h00, 24'h0, 1, 32'h00000000, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_INDEX8, pfc_pkg::KIND_PIXEL,
              32'h80FF0000, 8'h00, 24'h0, 0, 32'h0, 1'b0, 24'h0);
      add_row(pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_RGB565, pfc_pkg::KIND_PIXEL,
              32'h00A5C3E7, 8'h00, 24'h0, 0, 32'h0, 1'b0, 24'h0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_rows[i]) begin
         if (directed_rows[i].source_fmt != model_source_fmt ||
             directed_rows[i].target_fmt != model_target_fmt) begin
            wait_idle();
            set_formats(directed_rows[i].source_fmt, directed_rows[i].target_fmt);
         end
         send(directed_rows[i].kind, directed_rows[i].pixel, directed_rows[i].entry_index,
              directed_rows[i].entry_color, directed_rows[i].has_result,
              directed_rows[i].result);
      end

      // random traffic under every format setting, some settings without idling
      for (int s = 0; s < 4; s++) begin
         for (int t = 0; t < 4; t++) begin
            wait_idle();
            set_formats(pfc_pkg::pfc_format_type'(s), pfc_pkg::pfc_format_type'(t));
            idle_on = ((s * 4 + t) % 3 != 2);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
               kind = ($urandom_range(0, 4) == 0) ? pfc_pkg::KIND_PALETTE_WR
                                                  : pfc_pkg::KIND_PIXEL;
               case ($urandom_range(0, 9))
                  0:       pixel = 32'h00000000;
                  1:       pixel = 32'hFFFFFFFF;
                  default: pixel = $urandom;
               endcase
               send(kind, pixel, 8'($urandom), 24'($urandom), 1'b0,
                    '{32'h0, 1'b0, 24'h0});
               // sender holds off mid-stream until the output has caught up
               if (s == 0 && t == 2 && n == ITEMS_PER_SETTING / 2)
                  wait_idle();
            end
         end
      end

      wait_idle();
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

/* files.f */
sv/pfc_pkg.sv
sv/pfc_palette.sv
sv/pixel_format_converter.sv
sv/pfc_checker.sv
tb/testbench.sv
